/* sv/assert_macros.svh */
// Assertion macros shared by the row cosine similarity RTL.
// Standalone header; it has no dependencies. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequence must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
// The consequence must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* sv/rcs_pkg.sv */
// Types and constants of the row cosine similarity block.
// Used by the controller, the datapath and the top level; no dependencies.
package rcs_pkg;

    localparam int SAMPLE_W   = 16;  // Q1.15 sample width
    localparam int LEN_W      = 11;  // row length register width
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int SQ_W       = 41;  // width of the x*x and y*y sums
    localparam int XY_W       = 42;  // width of the signed x*y sum
    localparam int NORM_W     = 21;  // width of an integer root
    localparam int DEN_W      = 2 * NORM_W;
    localparam int COS_W      = 16;
    localparam int FRAC_BITS  = 15;
    localparam int NUM_W      = SQ_W + FRAC_BITS;
    localparam int SQRT_STEPS = 21;
    localparam int QUO_W      = 17;  // quotient bits kept; more means saturation
    localparam int DSH_W      = DEN_W + QUO_W - 1;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LEN_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_Y = 2'd1;

    typedef struct packed {
        logic accept;      // an element word is taken this cycle
        logic use_store;   // y comes from the stored row
        logic last;        // the element ends its row
        logic yvalid;      // y_norm is reported for this row
        logic sqrt_init;   // load the root unit
        logic sqrt_sel_y;  // root operand: 0 sum_xx, 1 sum_yy
        logic sqrt_step;   // one root iteration
        logic save_xn;     // keep the finished root as x_norm
        logic mul;         // form the denominator and |sum_xy|
        logic div_init;    // saturation check and divider load
        logic div_step;    // one quotient bit
        logic load_out;    // write the result word
        logic clear;       // clear the row sums
    } cmd_t;

    typedef struct packed {
        logic acc_last;    // the last product of a row is being summed
    } status_t;

endpackage

/* sv/rcs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the stored y row.
module rcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/rcs_ctrl.sv */
// Controller of the row cosine similarity block: configuration registers,
// element counter, row-end sequencer and output valid. Depends on rcs_pkg.
module rcs_ctrl
    import rcs_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int STORE_AW    = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  ram_we,
    output logic                  ram_re,
    output logic [STORE_AW-1:0]   ram_addr,
    output cmd_t                  cmd,
    input  status_t               status
);

    localparam logic [3:0] ST_ACC      = 4'd0;
    localparam logic [3:0] ST_DRAIN    = 4'd1;
    localparam logic [3:0] ST_SQX_INIT = 4'd2;
    localparam logic [3:0] ST_SQX_RUN  = 4'd3;
    localparam logic [3:0] ST_SQY_INIT = 4'd4;
    localparam logic [3:0] ST_SQY_RUN  = 4'd5;
    localparam logic [3:0] ST_MUL      = 4'd6;
    localparam logic [3:0] ST_CHK      = 4'd7;
    localparam logic [3:0] ST_DIV      = 4'd8;
    localparam logic [3:0] ST_FIN      = 4'd9;

    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(STORE_DEPTH);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [LEN_W-1:0]  row_length_reg, row_length_next;
    logic              bcast_reg, bcast_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic              first_row_reg, first_row_next;
    logic              out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]  eff_len;
    logic              is_last;
    logic              accept;

    always_comb begin
        if (row_length_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (row_length_reg > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = row_length_reg;
        end
    end

    assign is_last  = ({1'b0, count_reg} + (LEN_W + 1)'(1)) >= {1'b0, eff_len};
    assign s_ready  = (state_reg == ST_ACC);
    assign accept   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign ram_addr = count_reg[STORE_AW-1:0];
    assign ram_we   = accept && bcast_reg && first_row_reg;
    assign ram_re   = accept && bcast_reg && !first_row_reg;

    always_comb begin
        cmd             = '0;
        cmd.accept      = accept;
        cmd.use_store   = bcast_reg && !first_row_reg;
        cmd.last        = is_last;
        cmd.yvalid      = !bcast_reg || first_row_reg;
        state_next      = state_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        first_row_next  = first_row_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        row_length_next = row_length_reg;
        bcast_next      = bcast_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROW_LENGTH:  row_length_next = cfg_data;
                REG_BROADCAST_Y: bcast_next = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_ACC: begin
                if (accept) begin
                    if (is_last) begin
                        count_next     = '0;
                        first_row_next = !bcast_reg;
                        state_next     = ST_DRAIN;
                    end else begin
                        count_next = count_reg + LEN_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (status.acc_last) begin
                    state_next = ST_SQX_INIT;
                end
            end
            ST_SQX_INIT: begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = ST_SQX_RUN;
            end
            ST_SQX_RUN: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == SQRT_LAST) begin
                    state_next = ST_SQY_INIT;
                end
            end
            ST_SQY_INIT: begin
                cmd.save_xn    = 1'b1;
                cmd.sqrt_init  = 1'b1;
                cmd.sqrt_sel_y = 1'b1;
                step_next      = '0;
                state_next     = ST_SQY_RUN;
            end
            ST_SQY_RUN: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == SQRT_LAST) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == DIV_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out   = 1'b1;
                    cmd.clear      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_ACC;
            step_reg       <= '0;
            row_length_reg <= LEN_W'(1);
            bcast_reg      <= 1'b0;
            count_reg      <= '0;
            first_row_reg  <= 1'b1;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            row_length_reg <= row_length_next;
            bcast_reg      <= bcast_next;
            count_reg      <= count_next;
            first_row_reg  <= first_row_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

/* sv/rcs_datapath.sv */
// Datapath of the row cosine similarity block: product pipeline, row sums,
// shared bit-pair square root, restoring divider and result word registers.
// Depends on rcs_pkg; driven by rcs_ctrl commands.
module rcs_datapath
    import rcs_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic signed [SAMPLE_W-1:0] s_x_value,
    input  logic signed [SAMPLE_W-1:0] s_y_value,
    input  logic signed [SAMPLE_W-1:0] ram_rdata,
    output logic signed [COS_W-1:0]    m_cosine,
    output logic [NORM_W-1:0]          m_x_norm,
    output logic [NORM_W-1:0]          m_y_norm,
    output logic                       m_y_norm_valid,
    output logic                       m_zero_norm
);

    localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(32767);
    localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(32768);
    localparam logic signed [COS_W-1:0] COS_MAX = 16'sh7FFF;
    localparam logic signed [COS_W-1:0] COS_MIN = 16'sh8000;

    // Element pipeline.
    logic                       v1_reg, v2_reg;
    logic                       last1_reg, last2_reg;
    logic                       use1_reg;
    logic signed [SAMPLE_W-1:0] x1_reg, y1_reg;
    logic signed [SAMPLE_W-1:0] y_sel;
    logic signed [PROD_W-1:0]   pxx_reg, pyy_reg, pxy_reg;
    logic [SQ_W-1:0]            sum_xx_reg, sum_yy_reg;
    logic signed [XY_W-1:0]     sum_xy_reg;
    logic                       yv_reg;

    // Row-end arithmetic.
    logic [SQ_W-1:0]   sq_v_reg, sq_bit_reg;
    logic [SQ_W:0]     sq_r_reg, sq_trial;
    logic              sq_ge;
    logic [NORM_W-1:0] xn_reg, yn_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [SQ_W-1:0]   mag_reg;
    logic [XY_W-1:0]   mag_full;
    logic              neg_reg, sat_reg, zero_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic              div_ge;
    logic [QUO_W-1:0]  q_reg;
    logic signed [COS_W-1:0] cos_val;

    assign y_sel           = use1_reg ? ram_rdata : y1_reg;
    assign status.acc_last = v2_reg && last2_reg;

    assign sq_trial = sq_r_reg + {1'b0, sq_bit_reg};
    assign sq_ge    = {1'b0, sq_v_reg} >= sq_trial;
    assign mag_full = sum_xy_reg[XY_W-1] ? (XY_W'(0) - XY_W'(sum_xy_reg)) : XY_W'(sum_xy_reg);
    assign div_ge   = {{(DSH_W - NUM_W){1'b0}}, rem_reg} >= dsh_reg;

    always_comb begin
        if (zero_reg) begin
            cos_val = '0;
        end else if (neg_reg) begin
            if (sat_reg || q_reg > NEG_LIMIT) begin
                cos_val = COS_MIN;
            end else begin
                cos_val = COS_W'(QUO_W'(0) - q_reg);
            end
        end else begin
            if (sat_reg || q_reg > POS_LIMIT) begin
                cos_val = COS_MAX;
            end else begin
                cos_val = COS_W'(q_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
        end else begin
            v1_reg <= cmd.accept;
            v2_reg <= v1_reg;
            if (cmd.clear) begin
                sum_xx_reg <= '0;
                sum_yy_reg <= '0;
                sum_xy_reg <= '0;
            end else if (v2_reg) begin
                sum_xx_reg <= sum_xx_reg + SQ_W'(pxx_reg[PROD_W-2:0]);
                sum_yy_reg <= sum_yy_reg + SQ_W'(pyy_reg[PROD_W-2:0]);
                sum_xy_reg <= sum_xy_reg + XY_W'(pxy_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            x1_reg    <= s_x_value;
            y1_reg    <= s_y_value;
            use1_reg  <= cmd.use_store;
            last1_reg <= cmd.last;
            if (cmd.last) begin
                yv_reg <= cmd.yvalid;
            end
        end
        pxx_reg   <= x1_reg * x1_reg;
        pyy_reg   <= y_sel * y_sel;
        pxy_reg   <= x1_reg * y_sel;
        last2_reg <= last1_reg;

        if (cmd.sqrt_init) begin
            sq_v_reg   <= cmd.sqrt_sel_y ? sum_yy_reg : sum_xx_reg;
            sq_r_reg   <= '0;
            sq_bit_reg <= SQ_W'(1) << (2 * (SQRT_STEPS - 1));
        end else if (cmd.sqrt_step) begin
            if (sq_ge) begin
                sq_v_reg <= sq_v_reg - sq_trial[SQ_W-1:0];
                sq_r_reg <= (sq_r_reg >> 1) + {1'b0, sq_bit_reg};
            end else begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.save_xn) begin
            xn_reg <= sq_r_reg[NORM_W-1:0];
        end

        if (cmd.mul) begin
            yn_reg  <= sq_r_reg[NORM_W-1:0];
            den_reg <= xn_reg * sq_r_reg[NORM_W-1:0];
            neg_reg <= sum_xy_reg[XY_W-1];
            mag_reg <= mag_full[SQ_W-1:0];
        end

        // Any quotient of 2^17 or more saturates, so only 17 bits are formed.
        if (cmd.div_init) begin
            sat_reg  <= {{(DEN_W + 2 - SQ_W){1'b0}}, mag_reg} >= {den_reg, 2'b00};
            zero_reg <= (xn_reg == '0) || (yn_reg == '0);
            rem_reg  <= {mag_reg, {FRAC_BITS{1'b0}}};
            dsh_reg  <= {den_reg, {(QUO_W - 1){1'b0}}};
            q_reg    <= '0;
        end else if (cmd.div_step) begin
            if (div_ge) begin
                rem_reg <= rem_reg - dsh_reg[NUM_W-1:0];
            end
            q_reg   <= {q_reg[QUO_W-2:0], div_ge};
            dsh_reg <= dsh_reg >> 1;
        end

        if (cmd.load_out) begin
            m_cosine       <= cos_val;
            m_x_norm       <= xn_reg;
            m_y_norm       <= yv_reg ? yn_reg : '0;
            m_y_norm_valid <= yv_reg;
            m_zero_norm    <= zero_reg;
        end
    end

endmodule

/* sv/row_cosine_similarity.sv */
// Row cosine similarity: x.x, y.y and x.y sums over a configured row length,
// then integer root norms and a saturated Q1.15 cosine per row.
// Throughput: one element word per cycle within a row; the input closes after
// a row's last element while the pipeline drains, the shared root unit (21 steps
// each for x and y) and the 17-step divider run, and until the result word is loaded.
// Reset: synchronous, active low; it clears the sums, counters, config and valid.
`include "assert_macros.svh"

module row_cosine_similarity
    import rcs_pkg::*;
#(
    parameter int MAX_COLS = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration write port.
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    // Element pair input channel.
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_x_value,
    input  logic signed [SAMPLE_W-1:0] s_y_value,
    // Result channel.
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [COS_W-1:0]    m_cosine,
    output logic [NORM_W-1:0]          m_x_norm,
    output logic [NORM_W-1:0]          m_y_norm,
    output logic                       m_y_norm_valid,
    output logic                       m_zero_norm
);

    // A row never runs longer than the length register can express, so the
    // stored y row needs no more entries than that.
    localparam int LEN_LIMIT   = (1 << LEN_W) - 1;
    localparam int STORE_DEPTH = (MAX_COLS < LEN_LIMIT) ? MAX_COLS : LEN_LIMIT;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    cmd_t                       cmd;
    status_t                    status;
    logic                       ram_we;
    logic                       ram_re;
    logic [STORE_AW-1:0]        ram_addr;
    logic signed [SAMPLE_W-1:0] ram_rdata;

    // The controller owns the handshakes, the element counter and the
    // row-end sequence; the datapath only follows its commands.
    rcs_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .STORE_AW    (STORE_AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .cmd       (cmd),
        .status    (status)
    );

    // In broadcast mode the first row's y elements are written here and read
    // back by position on every later row; the registered read lands in the cycle
    // after the element word, in step with the product stage.
    rcs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH),
        .AW    (STORE_AW)
    ) u_y_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (s_y_value),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    rcs_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_x_value      (s_x_value),
        .s_y_value      (s_y_value),
        .ram_rdata      (ram_rdata),
        .m_cosine       (m_cosine),
        .m_x_norm       (m_x_norm),
        .m_y_norm       (m_y_norm),
        .m_y_norm_valid (m_y_norm_valid),
        .m_zero_norm    (m_zero_norm)
    );

    // Taking a row's last element closes the input for the row-end sequence.
    `ASSERT_NEXT(a_row_end_closes_input, aclk, aresetn, cmd.accept && cmd.last, !s_ready)
    // The final product of a row is summed only while the input is closed.
    `ASSERT_IMPLIES(a_drain_input_closed, aclk, aresetn, status.acc_last, !s_ready)
    // The y store is touched only by an accepted element word.
    `ASSERT_IMPLIES(a_store_on_accept, aclk, aresetn, ram_we || ram_re, s_valid && s_ready)
    // A result word is loaded only once the pipeline has drained.
    `ASSERT_IMPLIES(a_load_when_idle, aclk, aresetn, cmd.load_out, !status.acc_last && !s_ready)

endmodule
